/* rtl/scene_text_tokenizer_defines.svh */
// Assertion macros used by the tokenizer top level.
`ifndef SCENE_TEXT_TOKENIZER_DEFINES_SVH
`define SCENE_TEXT_TOKENIZER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sttok_pkg.sv */
// Shared types and codes of the scene text tokenizer.
package sttok_pkg;

  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;
  localparam int RUN_MAX     = 4;
  localparam int CNT_BITS    = $clog2(RUN_MAX + 1);

  // Event kinds
  localparam logic [2:0] EV_START = 3'd0;
  localparam logic [2:0] EV_CHAR  = 3'd1;
  localparam logic [2:0] EV_END   = 3'd2;
  localparam logic [2:0] EV_EOS   = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;

  // Token types
  localparam logic [1:0] TT_STRING  = 2'd0;
  localparam logic [1:0] TT_LBEGIN  = 2'd1;
  localparam logic [1:0] TT_LEND    = 2'd2;
  localparam logic [1:0] TT_LITERAL = 2'd3;

  // One result beat
  typedef struct packed {
    logic [2:0]             kind;
    logic [1:0]             ttype;
    logic [7:0]             ch;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } event_t;

  // All beats caused by one input item
  typedef struct packed {
    event_t [RUN_MAX-1:0] slot;
    logic [CNT_BITS-1:0]  cnt;
  } run_t;

endpackage

/* rtl/sttok_lexer.sv */
// Lexer state and per-byte event generation.
module sttok_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        byte_value,
  input  logic              end_of_input,
  output sttok_pkg::run_t   run
);
  import sttok_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_LITERAL,
    MODE_DONE
  } mode_t;

  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] tcol_r, tcol_nxt;
  logic [1:0]             ttype_r, ttype_nxt;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic ends_literal(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_LBR) || (c == CH_RBR) || (c == CH_COMMA) ||
           (c == CH_QUOTE) || is_space(c);
  endfunction

  function automatic event_t mk_ev(input logic [2:0] kind, input logic [1:0] ttype,
                                   input logic [7:0] ch, input logic [LINE_BITS-1:0] line,
                                   input logic [COLUMN_BITS-1:0] col);
    event_t e;
    e.kind  = kind;
    e.ttype = ttype;
    e.ch    = ch;
    e.line  = line;
    e.col   = col;
    e.last  = 1'b0;
    return e;
  endfunction

  // Work out the run of events and the next state for this byte
  always_comb begin
    logic [CNT_BITS-1:0] n;
    logic                do_idle;
    n         = '0;
    do_idle   = 1'b0;
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    ttype_nxt = ttype_r;
    run       = '0;

    if (mode_r != MODE_DONE) begin
      if (end_of_input) begin
        if (mode_r == MODE_STRING) begin
          run.slot[n[1:0]] = mk_ev(EV_ERROR, ttype_r, 8'h00, tline_r, tcol_r);
          n = n + 1'b1;
        end else if (mode_r == MODE_LITERAL) begin
          run.slot[n[1:0]] = mk_ev(EV_END, ttype_r, 8'h00, tline_r, tcol_r);
          n = n + 1'b1;
        end
        run.slot[n[1:0]] = mk_ev(EV_EOS, TT_STRING, 8'h00, '0, '0);
        n = n + 1'b1;
        mode_nxt = MODE_DONE;
      end else begin
        // Advance the location counters, saturating
        if (byte_value == CH_LF) begin
          if (line_r != '1) line_nxt = line_r + 1'b1;
          col_nxt = '0;
        end else if (col_r != '1) begin
          col_nxt = col_r + 1'b1;
        end

        case (mode_r)
          MODE_COMMENT: begin
            if (byte_value == CH_LF) mode_nxt = MODE_IDLE;
          end
          MODE_STRING: begin
            if (byte_value == CH_QUOTE) begin
              run.slot[n[1:0]] = mk_ev(EV_END, ttype_r, 8'h00, tline_r, tcol_r);
              n = n + 1'b1;
              mode_nxt = MODE_IDLE;
            end else begin
              run.slot[n[1:0]] = mk_ev(EV_CHAR, ttype_r, byte_value, tline_r, tcol_r);
              n = n + 1'b1;
            end
          end
          MODE_LITERAL: begin
            if (ends_literal(byte_value)) begin
              run.slot[n[1:0]] = mk_ev(EV_END, ttype_r, 8'h00, tline_r, tcol_r);
              n = n + 1'b1;
              mode_nxt = MODE_IDLE;
              do_idle  = 1'b1;
            end else begin
              run.slot[n[1:0]] = mk_ev(EV_CHAR, ttype_r, byte_value, tline_r, tcol_r);
              n = n + 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
            do_idle  = 1'b1;
          end
        endcase

        // Handle the byte as the start of something new
        if (do_idle && !is_space(byte_value)) begin
          if (byte_value == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            tline_nxt = line_nxt;
            tcol_nxt  = col_nxt;
            if (byte_value == CH_QUOTE) begin
              ttype_nxt = TT_STRING;
              run.slot[n[1:0]] = mk_ev(EV_START, TT_STRING, 8'h00, line_nxt, col_nxt);
              n = n + 1'b1;
              mode_nxt = MODE_STRING;
            end else if ((byte_value == CH_LBR) || (byte_value == CH_RBR)) begin
              ttype_nxt = (byte_value == CH_LBR) ? TT_LBEGIN : TT_LEND;
              run.slot[n[1:0]] = mk_ev(EV_START, ttype_nxt, 8'h00, line_nxt, col_nxt);
              n = n + 1'b1;
              run.slot[n[1:0]] = mk_ev(EV_CHAR, ttype_nxt, byte_value, line_nxt, col_nxt);
              n = n + 1'b1;
              run.slot[n[1:0]] = mk_ev(EV_END, ttype_nxt, 8'h00, line_nxt, col_nxt);
              n = n + 1'b1;
            end else begin
              ttype_nxt = TT_LITERAL;
              run.slot[n[1:0]] = mk_ev(EV_START, TT_LITERAL, 8'h00, line_nxt, col_nxt);
              n = n + 1'b1;
              run.slot[n[1:0]] = mk_ev(EV_CHAR, TT_LITERAL, byte_value, line_nxt, col_nxt);
              n = n + 1'b1;
              mode_nxt = MODE_LITERAL;
            end
          end
        end
      end
    end

    // Flag the final beat of the run
    if (n != '0) run.slot[n[1:0] - 2'd1].last = 1'b1;
    run.cnt = n;
  end

  // Hold lexer state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      line_r  <= '0;
      col_r   <= '0;
      tline_r <= '0;
      tcol_r  <= '0;
      ttype_r <= TT_STRING;
    end else if (take) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      ttype_r <= ttype_nxt;
    end
  end

endmodule

/* rtl/scene_text_tokenizer.sv */
// Top level of the scene text tokenizer: lexer plus result beat queue.
//
//   channel  direction  beat contents
//   in_      sink       byte_value, end_of_input
//   out_     source     event_kind, token_type, char_value, line_number,
//                       column_number, last_of_run
//
// An input beat is decoded in the cycle it is accepted; its events land in a
// four-slot run register and leave one per cycle on the result port while out_
// is not stalled. An input beat gives 0 to 4 events; a new input beat is taken
// in the cycle its predecessor's last event leaves, so beats giving one event or
// none flow one per cycle while out_ does not stall. Synchronous active-low
// reset empties the run register and returns the lexer to idle with all counters
// at zero. A stall on out_ holds the run and, while a run is pending, stalls in_.
`include "scene_text_tokenizer_defines.svh"

module scene_text_tokenizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_end_of_input,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_event_kind,
  output logic [1:0]                        out_token_type,
  output logic [7:0]                        out_char_value,
  output logic [sttok_pkg::LINE_BITS-1:0]   out_line_number,
  output logic [sttok_pkg::COLUMN_BITS-1:0] out_column_number,
  output logic                              out_last_of_run
);
  import sttok_pkg::*;

  run_t                 run;
  event_t [RUN_MAX-1:0] slots_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 take;
  logic                 emit;

  assign out_valid = (cnt_r != '0);
  assign emit      = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == '0) || ((cnt_r == CNT_BITS'(1)) && !out_stall));
  assign take      = in_valid && !in_stall;

  sttok_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .byte_value   (in_byte_value),
    .end_of_input (in_end_of_input),
    .run          (run)
  );

  // Load a fresh run or drop the beat just sent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= run.cnt;
    end else if (emit) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Shift the run payload toward the head slot
  always_ff @(posedge clk) begin
    if (take) begin
      slots_r <= run.slot;
    end else if (emit) begin
      for (int i = 0; i < RUN_MAX - 1; i++) slots_r[i] <= slots_r[i+1];
      slots_r[RUN_MAX-1] <= slots_r[RUN_MAX-1];
    end
  end

  assign out_event_kind    = slots_r[0].kind;
  assign out_token_type    = slots_r[0].ttype;
  assign out_char_value    = slots_r[0].ch;
  assign out_line_number   = slots_r[0].line;
  assign out_column_number = slots_r[0].col;
  assign out_last_of_run   = slots_r[0].last;

  `STT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_BITS'(RUN_MAX), "run count overflow")
  `STT_ASSERT_NOW(a_last_at_tail, out_valid && out_last_of_run, cnt_r == CNT_BITS'(1), "last flag before end of run")
  `STT_ASSERT_NOW(a_tail_is_last, out_valid && (cnt_r == CNT_BITS'(1)), out_last_of_run, "final beat of run not flagged")
  `STT_ASSERT_NOW(a_no_overwrite, take, (cnt_r == '0) || emit, "run overwritten before it drained")
  `STT_ASSERT_NEXT(a_quiet_after_eos, emit && (out_event_kind == EV_EOS), !out_valid, "result after end of stream")

endmodule
